// File: rtl/core/hpt_pkg.sv
// shared constants and types for the homogeneous point transform
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int QUO_W         = 32;
  localparam int NUM_REGS      = 8;
  localparam int IDX_W         = 8;
  localparam int DATA_W        = 64;
  localparam int DOT_LAT       = 3;
  localparam int DIV_LAT       = QUO_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

// File: rtl/core/hpt_if.sv
// channel interfaces: points in, results out, register writes
interface hpt_point_if import hpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hpt_result_if import hpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   w_zero;
  logic   saturated;
  modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface

interface hpt_cfg_if import hpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/hpt_dot.sv
// four dot products of the point (w = 1) with the matrix columns, three stages
module hpt_dot import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  coord_t pt [3],
  input  coord_t m [4][4],
  output logic   out_valid,
  output sum_t   s [4]
);

  logic signed [PROD_W-1:0] prod [3][4];
  sum_t tr [4];
  sum_t a [4];
  sum_t b [4];
  logic v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod[r][c] <= pt[r] * m[r][c];
        end
        tr[c] <= SUM_W'(m[3][c]) <<< FRAC_BITS;
        a[c]  <= SUM_W'(prod[0][c]) + SUM_W'(prod[1][c]);
        b[c]  <= SUM_W'(prod[2][c]) + tr[c];
        s[c]  <= a[c] + b[c];
      end
    end
  end

endmodule

// File: rtl/core/hpt_div.sv
// one quotient lane: sign/magnitude setup, 32 restoring steps, clamp
module hpt_div import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   en,
  input  sum_t   num,
  input  sum_t   den,
  output coord_t quo,
  output logic   sat
);

  localparam int NW = SUM_W + FRAC_BITS;
  localparam int RW = SUM_W + 1;
  localparam int CW = SUM_W + QUO_W;

  logic [SUM_W-1:0] na, da;
  logic [NW-1:0]    n;
  logic             ovf_c;

  logic [RW-1:0]    rem [QUO_W+1];
  logic [QUO_W-1:0] lo  [QUO_W+1];
  logic [SUM_W-1:0] d   [QUO_W+1];
  logic             neg [QUO_W+1];
  logic             ovf [QUO_W+1];

  logic [RW-1:0]    trial [QUO_W];
  logic             ge    [QUO_W];

  logic [QUO_W-1:0] lim, mag;
  logic             sat_c;

  always_comb begin
    na    = num[SUM_W-1] ? (~num + 1'b1) : num;
    da    = den[SUM_W-1] ? (~den + 1'b1) : den;
    n     = NW'(na) << FRAC_BITS;
    // quotient of 2^32 or more clamps in any case
    ovf_c = CW'(n) >= {da, QUO_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(n >> QUO_W);
      lo[0]  <= n[QUO_W-1:0];
      d[0]   <= da;
      neg[0] <= num[SUM_W-1] ^ den[SUM_W-1];
      ovf[0] <= ovf_c;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    always_comb begin
      trial[i] = {rem[i][RW-2:0], lo[i][QUO_W-1]};
      ge[i]    = trial[i] >= {1'b0, d[i]};
    end

    // numerator bits shift out of lo as quotient bits shift in
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge[i] ? (trial[i] - {1'b0, d[i]}) : trial[i];
        lo[i+1]  <= {lo[i][QUO_W-2:0], ge[i]};
        d[i+1]   <= d[i];
        neg[i+1] <= neg[i];
        ovf[i+1] <= ovf[i];
      end
    end
  end

  always_comb begin
    lim   = neg[QUO_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat_c = ovf[QUO_W] || (lo[QUO_W] > lim);
    mag   = sat_c ? lim : lo[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[QUO_W] ? (~mag + 1'b1) : mag;
      sat <= sat_c;
    end
  end

endmodule

// File: rtl/core/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide.
// A point (point_x, point_y, point_z, signed Q16.16) arrives on the point
// channel and is taken as a row vector with w = 1. It is multiplied by the
// 4x4 matrix held in eight 64-bit registers (two entries per register, even
// column in the low half), and X, Y, Z are divided by W, truncated toward
// zero and clamped to signed 32 bits; saturated flags any clamp. A W of
// exactly zero gives zero coordinates with w_zero set.
// Registers are written on the cfg channel (index 0..7, others ignored),
// always ready; the user must write them only while no point is in flight,
// which the block itself does not enforce. A point passes through products
// and sums, sign and magnitude setup, the restoring divider (one quotient
// bit per stage) and the clamp, which is also the output register.
// Throughput is one point per cycle unless the output stalls. All stages
// advance together whenever the output register is empty or its transfer
// completes; a stalled receiver holds every stage, nothing lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads the identity.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  hpt_point_if.sink     point,
  hpt_result_if.source  result,
  hpt_cfg_if.sink       cfg
);

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] mreg [NUM_REGS];
  coord_t            m [4][4];
  coord_t            pt [3];
  logic              en;
  logic              dot_valid;
  sum_t              s [4];
  logic              vld [DIV_LAT];
  logic              wz  [DIV_LAT];
  coord_t            q   [3];
  logic              qs  [3];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= {32'b0, ONE};
      mreg[1] <= '0;
      mreg[2] <= {ONE, 32'b0};
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= {32'b0, ONE};
      mreg[6] <= '0;
      mreg[7] <= {ONE, 32'b0};
    end else if (cfg.valid && cfg.index < IDX_W'(NUM_REGS)) begin
      mreg[cfg.index[2:0]] <= cfg.data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = mreg[2*r][31:0];
      m[r][1] = mreg[2*r][63:32];
      m[r][2] = mreg[2*r+1][31:0];
      m[r][3] = mreg[2*r+1][63:32];
    end
    pt[0] = point.point_x;
    pt[1] = point.point_y;
    pt[2] = point.point_z;
  end

  assign en          = result.ready || !vld[DIV_LAT-1];
  assign point.ready = en;

  hpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (point.valid),
    .pt        (pt),
    .m         (m),
    .out_valid (dot_valid),
    .s         (s)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (s[c]),
      .den (s[3]),
      .quo (q[c]),
      .sat (qs[c])
    );
  end

  // valid and w-zero flags ride alongside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= dot_valid;
      for (int i = 1; i < DIV_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz[0] <= (s[3] == '0);
      for (int i = 1; i < DIV_LAT; i++) wz[i] <= wz[i-1];
    end
  end

  assign result.valid     = vld[DIV_LAT-1];
  assign result.w_zero    = wz[DIV_LAT-1];
  assign result.out_x     = wz[DIV_LAT-1] ? '0 : q[0];
  assign result.out_y     = wz[DIV_LAT-1] ? '0 : q[1];
  assign result.out_z     = wz[DIV_LAT-1] ? '0 : q[2];
  assign result.saturated = !wz[DIV_LAT-1] && (qs[0] || qs[1] || qs[2]);

  a_wz_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.w_zero |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0 && !result.saturated)
    else $error("w_zero result carries nonzero data");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      result.out_x == 32'sh7FFF_FFFF || result.out_x == 32'sh8000_0000 ||
      result.out_y == 32'sh7FFF_FFFF || result.out_y == 32'sh8000_0000 ||
      result.out_z == 32'sh7FFF_FFFF || result.out_z == 32'sh8000_0000)
    else $error("saturated without a clamped coordinate");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[DIV_LAT-1]) && $stable(q[0]) && $stable(wz[DIV_LAT-1]))
    else $error("pipeline moved while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    point.ready == (result.ready || !result.valid))
    else $error("input ready out of step with output stall");

endmodule

// File: verif/homogeneous_point_transform_checker.sv
// checker: watches the channels, predicts each transformed point and compares
module homogeneous_point_transform_checker import hpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  hpt_point_if   point,
  hpt_result_if  result,
  hpt_cfg_if     cfg,
  output int     outstanding,
  output int     mismatches
);

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_zero;
    logic   saturated;
  } projected_t;

  logic [DATA_W-1:0] matrix [NUM_REGS];
  projected_t        projected_q [$];

  function automatic logic signed [127:0] matrix_entry(int r, int c);
    logic signed [31:0] e;
    e = matrix[2 * r + c / 2][(c % 2) * 32 +: 32];
    return e;
  endfunction

  function automatic projected_t project(coord_t px, coord_t py, coord_t pz);
    logic signed [127:0] sum [4];
    logic signed [127:0] p [3];
    logic [127:0]        num, den, q, lim;
    logic                neg;
    projected_t          res;
    coord_t              o [3];
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    res = '0;
    for (int c = 0; c < 4; c++) begin
      sum[c] = matrix_entry(3, c) <<< FRAC;
      for (int r = 0; r < 3; r++) sum[c] += p[r] * matrix_entry(r, c);
    end
    if (sum[3] == 0) begin
      res.w_zero = 1'b1;
      return res;
    end
    den = sum[3][127] ? -sum[3] : sum[3];
    for (int c = 0; c < 3; c++) begin
      neg = sum[c][127] ^ sum[3][127];
      num = (sum[c][127] ? -sum[c] : sum[c]) << FRAC;
      q = num / den;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        res.saturated = 1'b1;
        q = lim;
      end
      o[c] = neg ? -q[31:0] : q[31:0];
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  always @(posedge clk) begin
    projected_t want, got;
    if (rst) begin
      matrix[0] <= 64'd1 << FRAC;
      matrix[1] <= '0;
      matrix[2] <= (64'd1 << FRAC) << 32;
      matrix[3] <= '0;
      matrix[4] <= '0;
      matrix[5] <= 64'd1 << FRAC;
      matrix[6] <= '0;
      matrix[7] <= (64'd1 << FRAC) << 32;
      projected_q.delete();
      outstanding <= 0;
      mismatches <= 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
        matrix[cfg.index[2:0]] <= cfg.data;
      if (point.valid && point.ready)
        projected_q.push_back(project(point.point_x, point.point_y, point.point_z));
      if (result.valid && result.ready) begin
        got = {result.out_x, result.out_y, result.out_z, result.w_zero, result.saturated};
        if (projected_q.size() == 0) begin
          if (mismatches < 10) $display("result with nothing pending: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = projected_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= projected_q.size();
    end
  end

endmodule

// File: verif/homogeneous_point_transform_test.sv
// testbench top: stimulus, receiver stalls, config phases and verdict
module homogeneous_point_transform_test;
  import hpt_pkg::*;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   outstanding;
  int   mismatches;
  int   cycles;
  int   sent;
  logic hold_off;

  hpt_point_if  point ();
  hpt_result_if result ();
  hpt_cfg_if    cfg ();

  homogeneous_point_transform dut (
    .clk(clk), .rst(rst), .point(point), .result(result), .cfg(cfg)
  );

  homogeneous_point_transform_checker checker_i (
    .clk(clk), .rst(rst), .point(point), .result(result), .cfg(cfg),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= rst ? 0 : cycles + 1;
    if (!rst && cycles > CYCLE_LIMIT) begin
      $display("homogeneous_point_transform_test NOT OK");
      $finish;
    end
  end

  // receiver pattern rotates through always ready, coin flip and sparse
  always @(posedge clk) begin
    if (rst || hold_off) result.ready <= 1'b0;
    else case ((cycles / 64) % 3)
      0: result.ready <= 1'b1;
      1: result.ready <= 1'($urandom_range(1, 0));
      default: result.ready <= ($urandom_range(3, 0) == 0);
    endcase
  end

  // long hold-off once the stream is running, so the pipeline fills up
  initial begin
    hold_off = 1'b0;
    wait (sent == 250);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  int burst_left;

  task automatic wait_transfer(ref logic ready_sig);
    logic done;
    do begin
      @(negedge clk);
      done = ready_sig;
      @(posedge clk);
    end while (!done);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point.valid   <= 1'b1;
    point.point_x <= x;
    point.point_y <= y;
    point.point_z <= z;
    wait_transfer(point.ready);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      point.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
    end
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    wait_transfer(cfg.ready);
  endtask

  task automatic drain;
    point.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DOT_LAT + DIV_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4, 0))
      0: return $urandom();
      1: return {$urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $signed($urandom_range(20 * ONE, 0)) - $signed(10 * ONE);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    if ($urandom_range(5, 0) == 0) return $urandom();
    return $signed($urandom_range(8 * ONE, 0)) - $signed(4 * ONE);
  endfunction

  task automatic load_matrix(logic [31:0] e [16]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDX_W'(i), {e[2 * i + 1], e[2 * i]});
    cfg.valid <= 1'b0;
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  logic [31:0] edge_vals [5] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1};
  logic [31:0] m [16];

  initial begin
    rst           = 1'b1;
    point.valid   = 1'b0;
    point.point_x = '0;
    point.point_y = '0;
    point.point_z = '0;
    cfg.valid     = 1'b0;
    cfg.index     = '0;
    cfg.data      = '0;
    burst_left    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset: field extremes pass straight through
    for (int i = 0; i < 5; i++) send_point(edge_vals[i], edge_vals[(i + 1) % 5],
                                           edge_vals[(i + 3) % 5]);
    random_points(40);
    drain();

    // w = x - 1.0: zero w at x = 1.0, tiny w near it drives saturation
    foreach (m[i]) m[i] = '0;
    m[0] = ONE; m[5] = ONE; m[10] = ONE; m[3] = ONE; m[15] = -ONE;
    m[12] = 3 * ONE;
    load_matrix(m);
    write_reg(8'd8, '1);
    write_reg(8'hff, '1);
    cfg.valid <= 1'b0;
    send_point(ONE, 32'h7fff_ffff, 32'h8000_0000);
    send_point(ONE, 0, 0);
    send_point(ONE + 1, 32'h7fff_ffff, 5 * ONE);
    send_point(ONE - 1, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    for (int i = 0; i < 60; i++)
      send_point(($urandom_range(1, 0) ? ONE : ONE + $urandom_range(4, 0) - 2),
                 rand_coord(), rand_coord());
    drain();

    // matrix extremes: every entry at the top or bottom of its range
    foreach (m[i]) m[i] = $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
    load_matrix(m);
    for (int i = 0; i < 5; i++) send_point(edge_vals[i], edge_vals[4 - i], edge_vals[i]);
    random_points(40);
    drain();

    // all-zero matrix: every point gives zero w
    foreach (m[i]) m[i] = '0;
    load_matrix(m);
    random_points(15);
    drain();

    // several random matrices
    for (int k = 0; k < 4; k++) begin
      foreach (m[i]) m[i] = rand_entry();
      if (k == 0) m[15] = ONE;
      load_matrix(m);
      random_points(k == 0 ? 100 : 40);
      drain();
    end

    if (mismatches == 0) begin
      $display("homogeneous_point_transform_test OK");
    end else begin
      $display("homogeneous_point_transform_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_if.sv
rtl/core/hpt_dot.sv
rtl/core/hpt_div.sv
rtl/core/homogeneous_point_transform.sv
verif/homogeneous_point_transform_checker.sv
verif/homogeneous_point_transform_test.sv
